// ===== design/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// Topological sort engine package
// Shared widths, codes, a control structure and a helper function.
// ----------------------------------------------------------------------------
package tse_pkg;

   localparam int MAX_NODES = 32;
   localparam int NODE_W    = 5;
   localparam int CNT_W     = 6;
   localparam int DEG_W     = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 6;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_EDGE  = 2'd1,
      CMD_SORT  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIORITY   = 2'd1;

   typedef struct packed {
      logic clear;
      logic accumulate;
      logic decrement;
   } lane_ctrl_type;

   function automatic logic [NODE_W-1:0] lowest_index(input logic [MAX_NODES-1:0] mask);
      logic [NODE_W-1:0] idx;
      idx = '0;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (mask[i]) begin
            idx = NODE_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== design/tse_if.sv =====
// ----------------------------------------------------------------------------
// Topological sort engine channels
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface tse_req_if;
   import tse_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic [NODE_W-1:0] from_node;
   logic [NODE_W-1:0] to_node;
   modport source (output valid, command, from_node, to_node, input ready);
   modport sink (input valid, command, from_node, to_node, output ready);
endinterface

interface tse_rsp_if;
   import tse_pkg::*;
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] node;
   logic              last;
   logic              cycle_found;
   modport source (output valid, node, last, cycle_found, input ready);
   modport sink (input valid, node, last, cycle_found, output ready);
endinterface

interface tse_csr_if;
   import tse_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/tse_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/tse_lanes.sv =====
// ----------------------------------------------------------------------------
// Topological sort engine degree lanes
// One in-degree counter per node, counted up from rows and counted down.
// ----------------------------------------------------------------------------
module tse_lanes (
   input  logic                            clock,
   input  tse_pkg::lane_ctrl_type          ctrl,
   input  logic [tse_pkg::MAX_NODES-1:0]   row,
   output logic [tse_pkg::MAX_NODES-1:0]   zero_mask,
   output logic [tse_pkg::MAX_NODES-1:0]   hit_mask
);
   import tse_pkg::*;

   logic [DEG_W-1:0] deg_ff [MAX_NODES];
   logic [DEG_W-1:0] deg_in [MAX_NODES];

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         deg_in[i]    = deg_ff[i];
         zero_mask[i] = (deg_ff[i] == '0);
         hit_mask[i]  = row[i] && (deg_ff[i] == DEG_W'(1));
         if (ctrl.clear) begin
            deg_in[i] = '0;
         end else if (ctrl.accumulate && row[i]) begin
            deg_in[i] = deg_ff[i] + DEG_W'(1);
         end else if (ctrl.decrement && row[i] && (deg_ff[i] != '0)) begin
            deg_in[i] = deg_ff[i] - DEG_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_NODES; i++) begin
         deg_ff[i] <= deg_in[i];
      end
   end

endmodule

// ===== design/topological_sort_engine_top.sv =====
// Sort first counts in-degrees by reading each adjacency row, then pops nodes and reads
// each popped node's row from the adjacency RAM to lower the degrees of its successors.
// Results then leave one item at a time, each waiting for the result channel to accept it.
// Only one command is worked on at a time; a new item is taken when the previous is done.
// Reset is synchronous and clears the graph, node_count to 1 and priority_mode to 0.
// ----------------------------------------------------------------------------
// Topological sort engine
// Kahn sort over an adjacency RAM with FIFO or lowest-index ready order.
// ----------------------------------------------------------------------------
module topological_sort_engine_top (
   input  logic      clock,
   input  logic      reset,
   tse_req_if.sink   req_chan,
   tse_rsp_if.source rsp_chan,
   tse_csr_if.sink   csr_chan
);
   import tse_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_EDGE_WR  = 14'b00000000000010,
      S_DEG_RD   = 14'b00000000000100,
      S_DEG_ACC  = 14'b00000000001000,
      S_SEED     = 14'b00000000010000,
      S_DRAIN    = 14'b00000000100000,
      S_POP      = 14'b00000001000000,
      S_POP_WAIT = 14'b00000010000000,
      S_ROW_RD   = 14'b00000100000000,
      S_ROW_WAIT = 14'b00001000000000,
      S_FINISH   = 14'b00010000000000,
      S_OUT_RD   = 14'b00100000000000,
      S_OUT_LD   = 14'b01000000000000,
      S_OUT_WAIT = 14'b10000000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     node_count_ff, node_count_in;
   logic                 prio_ff, prio_in;
   logic [MAX_NODES-1:0] row_valid_ff, row_valid_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic [CNT_W-1:0]     emitted_ff, emitted_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [NODE_W-1:0]    cur_ff, cur_in;
   logic [NODE_W-1:0]    dst_ff, dst_in;
   logic [NODE_W-1:0]    adj_raddr_ff;
   logic [MAX_NODES-1:0] ready_ff, ready_in;
   logic [MAX_NODES-1:0] new_ff, new_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]    rsp_node_ff, rsp_node_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_cycle_ff, rsp_cycle_in;

   logic [CNT_W-1:0]     n_act;
   logic [MAX_NODES-1:0] col_mask;
   logic [MAX_NODES-1:0] adj_rdata, adj_row, row_masked, adj_wdata;
   logic                 adj_we;
   logic [NODE_W-1:0]    adj_waddr, adj_raddr;
   logic                 ord_we;
   logic [NODE_W-1:0]    ord_waddr, ord_wdata, ord_raddr, ord_rdata;
   logic [MAX_NODES-1:0] zero_mask, hit_mask;
   lane_ctrl_type        lane_ctrl;
   logic                 req_fire;
   logic [NODE_W-1:0]    pick;

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.node    = rsp_node_ff;
   assign rsp_chan.last    = rsp_last_ff;
   assign rsp_chan.cycle_found = rsp_cycle_ff;

   always_comb begin
      if (node_count_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (node_count_ff > CNT_W'(MAX_NODES)) begin
         n_act = CNT_W'(MAX_NODES);
      end else begin
         n_act = node_count_ff;
      end
      for (int i = 0; i < MAX_NODES; i++) begin
         col_mask[i] = (CNT_W'(i) < n_act);
      end
   end

   assign adj_row    = row_valid_ff[adj_raddr_ff] ? adj_rdata : '0;
   assign row_masked = adj_row & col_mask;

   tse_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   tse_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   tse_lanes u_lanes (
      .clock     (clock),
      .ctrl      (lane_ctrl),
      .row       (row_masked),
      .zero_mask (zero_mask),
      .hit_mask  (hit_mask)
   );

   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      prio_in       = prio_ff;
      row_valid_in  = row_valid_ff;
      j_in          = j_ff;
      emitted_in    = emitted_ff;
      fill_in       = fill_ff;
      k_in          = k_ff;
      cur_in        = cur_ff;
      dst_in        = dst_ff;
      ready_in      = ready_ff;
      new_in        = new_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_cycle_in  = rsp_cycle_ff;
      adj_we        = 1'b0;
      adj_waddr     = adj_raddr_ff;
      adj_wdata     = adj_row | (MAX_NODES'(1) << dst_ff);
      adj_raddr     = cur_ff;
      ord_we        = 1'b0;
      ord_waddr     = fill_ff[NODE_W-1:0];
      ord_wdata     = lowest_index(new_ff);
      ord_raddr     = emitted_ff[NODE_W-1:0];
      lane_ctrl     = '0;
      pick          = lowest_index(ready_ff);

      if (csr_chan.valid) begin
         if (csr_chan.index == CSR_NODE_COUNT) begin
            node_count_in = csr_chan.data;
         end else if (csr_chan.index == CSR_PRIORITY) begin
            prio_in = csr_chan.data[0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            adj_raddr = req_chan.from_node;
            if (req_fire) begin
               unique case (cmd_type'(req_chan.command))
                  CMD_CLEAR: begin
                     row_valid_in = '0;
                  end
                  CMD_EDGE: begin
                     dst_in = req_chan.to_node;
                     if ((CNT_W'(req_chan.from_node) < n_act) &&
                         (CNT_W'(req_chan.to_node) < n_act)) begin
                        state_in = S_EDGE_WR;
                     end
                  end
                  CMD_SORT: begin
                     lane_ctrl.clear = 1'b1;
                     j_in       = '0;
                     emitted_in = '0;
                     fill_in    = '0;
                     ready_in   = '0;
                     new_in     = '0;
                     state_in   = S_DEG_RD;
                  end
                  CMD_NONE: begin
                  end
               endcase
            end
         end
         S_EDGE_WR: begin
            adj_we = 1'b1;
            row_valid_in[adj_raddr_ff] = 1'b1;
            state_in = S_IDLE;
         end
         S_DEG_RD: begin
            adj_raddr = j_ff[NODE_W-1:0];
            state_in  = S_DEG_ACC;
         end
         S_DEG_ACC: begin
            lane_ctrl.accumulate = 1'b1;
            j_in = j_ff + CNT_W'(1);
            state_in = (j_ff + CNT_W'(1) == n_act) ? S_SEED : S_DEG_RD;
         end
         S_SEED: begin
            if (prio_ff) begin
               ready_in = zero_mask & col_mask;
               state_in = S_POP;
            end else begin
               new_in   = zero_mask & col_mask;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (new_ff == '0) begin
               state_in = S_POP;
            end else begin
               ord_we  = 1'b1;
               fill_in = fill_ff + CNT_W'(1);
               new_in  = new_ff & ~(MAX_NODES'(1) << ord_wdata);
            end
         end
         S_POP: begin
            if (prio_ff) begin
               if (ready_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  ord_we     = 1'b1;
                  ord_waddr  = emitted_ff[NODE_W-1:0];
                  ord_wdata  = pick;
                  cur_in     = pick;
                  ready_in   = ready_ff & ~(MAX_NODES'(1) << pick);
                  emitted_in = emitted_ff + CNT_W'(1);
                  state_in   = S_ROW_RD;
               end
            end else begin
               state_in = (emitted_ff == fill_ff) ? S_FINISH : S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            cur_in     = ord_rdata;
            emitted_in = emitted_ff + CNT_W'(1);
            state_in   = S_ROW_RD;
         end
         S_ROW_RD: begin
            state_in = S_ROW_WAIT;
         end
         S_ROW_WAIT: begin
            lane_ctrl.decrement = 1'b1;
            if (prio_ff) begin
               ready_in = ready_ff | hit_mask;
               state_in = S_POP;
            end else begin
               new_in   = hit_mask;
               state_in = S_DRAIN;
            end
         end
         S_FINISH: begin
            k_in = '0;
            if (emitted_ff != n_act) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_cycle_in = 1'b1;
               state_in     = S_OUT_WAIT;
            end else begin
               state_in = S_OUT_RD;
            end
         end
         S_OUT_RD: begin
            ord_raddr = k_ff[NODE_W-1:0];
            state_in  = S_OUT_LD;
         end
         S_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_node_in  = ord_rdata;
            rsp_last_in  = (k_ff + CNT_W'(1) == n_act);
            rsp_cycle_in = 1'b0;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               k_in = k_ff + CNT_W'(1);
               state_in = rsp_last_ff ? S_IDLE : S_OUT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= CNT_W'(1);
         prio_ff       <= 1'b0;
         row_valid_ff  <= '0;
         j_ff          <= '0;
         emitted_ff    <= '0;
         fill_ff       <= '0;
         k_ff          <= '0;
         ready_ff      <= '0;
         new_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         adj_raddr_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         prio_ff       <= prio_in;
         row_valid_ff  <= row_valid_in;
         j_ff          <= j_in;
         emitted_ff    <= emitted_in;
         fill_ff       <= fill_in;
         k_ff          <= k_in;
         ready_ff      <= ready_in;
         new_ff        <= new_in;
         rsp_valid_ff  <= rsp_valid_in;
         adj_raddr_ff  <= adj_raddr;
      end
      cur_ff       <= cur_in;
      dst_ff       <= dst_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_cycle_ff <= rsp_cycle_in;
   end

   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_OUT_WAIT))
      else $error("Result valid outside the result wait state.");

   a_cycle_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cycle_ff) |-> (rsp_last_ff && (rsp_node_ff == '0)))
      else $error("Cycle result is not a single zero-node last item.");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (emitted_ff <= CNT_W'(MAX_NODES)) && (fill_ff <= CNT_W'(MAX_NODES)))
      else $error("Emitted or queued count exceeds the node limit.");

   a_fifo_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP_WAIT) |-> (emitted_ff < fill_ff))
      else $error("Queue read past its fill level.");

endmodule
